FILE: design/hhlp_pkg.sv
package hhlp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_MAX_LINE_LENGTH   = 2'd0;
  localparam logic [1:0] REG_MAX_LEADING_SPACE = 2'd1;
  localparam logic [1:0] REG_STRICT_LINE_END   = 2'd2;

  localparam logic [15:0] MAX_LINE_LENGTH_RESET   = 16'd1024;
  localparam logic [7:0]  MAX_LEADING_SPACE_RESET = 8'd8;
  localparam logic        STRICT_LINE_END_RESET   = 1'b0;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic KIND_PARSE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    PH_NAME    = 3'd0,
    PH_SPACE   = 3'd1,
    PH_VALUE   = 3'd2,
    PH_LF      = 3'd3,
    PH_VALID   = 3'd4,
    PH_ERR_LEN = 3'd5,
    PH_ERR_WS  = 3'd6,
    PH_ERR_EOL = 3'd7
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } item_beat_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       accepted;
    logic       name_valid;
    logic [7:0] name_char;
    logic       value_valid;
    logic [7:0] value_char;
  } result_beat_t;

  typedef struct packed {
    logic [15:0] max_line_length;
    logic [7:0]  max_leading_space;
    logic        strict_line_end;
  } cfg_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

FILE: design/hhlp_cfg.sv
module hhlp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hhlp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [hhlp_pkg::DATA_BITS-1:0] pwdata,
  output logic [hhlp_pkg::DATA_BITS-1:0] prdata,
  output hhlp_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign reg_index = paddr[3:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_line_length   <= hhlp_pkg::MAX_LINE_LENGTH_RESET;
      cfg.max_leading_space <= hhlp_pkg::MAX_LEADING_SPACE_RESET;
      cfg.strict_line_end   <= hhlp_pkg::STRICT_LINE_END_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        hhlp_pkg::REG_MAX_LINE_LENGTH:   cfg.max_line_length   <= pwdata[15:0];
        hhlp_pkg::REG_MAX_LEADING_SPACE: cfg.max_leading_space <= pwdata[7:0];
        hhlp_pkg::REG_STRICT_LINE_END:   cfg.strict_line_end   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      hhlp_pkg::REG_MAX_LINE_LENGTH:
        prdata = hhlp_pkg::DATA_BITS'(cfg.max_line_length);
      hhlp_pkg::REG_MAX_LEADING_SPACE:
        prdata = hhlp_pkg::DATA_BITS'(cfg.max_leading_space);
      hhlp_pkg::REG_STRICT_LINE_END:
        prdata = hhlp_pkg::DATA_BITS'(cfg.strict_line_end);
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: design/hhlp_step.sv
module hhlp_step #(
  parameter int LENGTH_BITS = hhlp_pkg::LENGTH_BITS_DEFAULT
) (
  input  hhlp_pkg::item_beat_t   item,
  input  hhlp_pkg::cfg_t         cfg,
  input  hhlp_pkg::phase_t       phase,
  input  logic [LENGTH_BITS-1:0] line_count,
  input  logic [7:0]             space_count,
  output hhlp_pkg::phase_t       phase_next,
  output logic [LENGTH_BITS-1:0] line_count_next,
  output logic [7:0]             space_count_next,
  output hhlp_pkg::result_beat_t result
);

  localparam int CMP_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [LENGTH_BITS-1:0] count_inc;
  logic                   too_long;
  logic                   space_over;
  logic [7:0]             c;
  hhlp_pkg::phase_t       ph;

  assign c = item.byte_in;
  assign count_inc = (line_count != '1) ? line_count + LENGTH_BITS'(1) : line_count;
  assign too_long = CMP_BITS'(count_inc) > CMP_BITS'(cfg.max_line_length);
  assign space_over = ({1'b0, space_count} + 9'd1) > {1'b0, cfg.max_leading_space};
  assign ph = too_long ? hhlp_pkg::PH_ERR_LEN : phase;

  always_comb begin
    phase_next = phase;
    line_count_next = line_count;
    space_count_next = space_count;
    result = '0;
    if (item.kind == hhlp_pkg::KIND_CLEAR) begin
      phase_next = hhlp_pkg::PH_NAME;
      line_count_next = '0;
      space_count_next = '0;
    end else begin
      line_count_next = count_inc;
      phase_next = ph;
      unique case (ph)
        hhlp_pkg::PH_NAME: begin
          if (hhlp_pkg::is_letter(c) || c == hhlp_pkg::CH_HYPHEN) begin
            result.name_valid = 1'b1;
            result.name_char = c | hhlp_pkg::CASE_BIT;
            result.accepted = 1'b1;
          end else if (c == hhlp_pkg::CH_COLON) begin
            phase_next = hhlp_pkg::PH_SPACE;
            result.accepted = 1'b1;
          end
        end
        hhlp_pkg::PH_SPACE, hhlp_pkg::PH_VALUE: begin
          if (ph == hhlp_pkg::PH_SPACE &&
              (c == hhlp_pkg::CH_SPACE || c == hhlp_pkg::CH_TAB)) begin
            if (space_over) begin
              phase_next = hhlp_pkg::PH_ERR_WS;
            end else begin
              space_count_next = space_count + 8'd1;
              result.accepted = 1'b1;
            end
          end else if (c == hhlp_pkg::CH_CR) begin
            phase_next = hhlp_pkg::PH_LF;
            result.accepted = 1'b1;
          end else if (c == hhlp_pkg::CH_LF) begin
            if (cfg.strict_line_end) begin
              phase_next = hhlp_pkg::PH_ERR_EOL;
            end else begin
              phase_next = hhlp_pkg::PH_VALID;
              result.accepted = 1'b1;
            end
          end else begin
            phase_next = hhlp_pkg::PH_VALUE;
            result.value_valid = 1'b1;
            result.value_char = c;
            result.accepted = 1'b1;
          end
        end
        hhlp_pkg::PH_LF: begin
          if (c == hhlp_pkg::CH_LF) begin
            phase_next = hhlp_pkg::PH_VALID;
            result.accepted = 1'b1;
          end
        end
        default: ;
      endcase
    end
    result.phase = phase_next;
  end

endmodule

FILE: design/http_header_line_parser_core.sv
// Header field line parser: every beat on the item channel is a parse byte or
// a line clear, and gives exactly one result beat. A beat is captured in an
// item register and the per-byte parse step runs combinationally into the
// result register, so the block sustains one byte per clock unless the result
// side stalls. Result stall backs up through the item register, so item_stall
// rises only when both registers are full and the result is not taken. The
// user must set limits and line end mode over the APB port only while no byte
// is in flight; the block does not enforce it. Valid and error phases hold
// until a clear beat, but an overlong line moves them to the length error.
module http_header_line_parser_core #(
  parameter int LENGTH_BITS = hhlp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hhlp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [hhlp_pkg::DATA_BITS-1:0] pwdata,
  output logic [hhlp_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  hhlp_pkg::item_beat_t           item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output hhlp_pkg::result_beat_t         result
);

  hhlp_pkg::cfg_t         cfg;
  logic                   item_full;
  hhlp_pkg::item_beat_t   item_reg;
  logic                   advance;
  hhlp_pkg::phase_t       phase;
  hhlp_pkg::phase_t       phase_next;
  logic [LENGTH_BITS-1:0] line_count;
  logic [LENGTH_BITS-1:0] line_count_next;
  logic [7:0]             space_count;
  logic [7:0]             space_count_next;
  hhlp_pkg::result_beat_t result_next;

  assign pready = 1'b1;

  hhlp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  hhlp_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .item             (item_reg),
    .cfg              (cfg),
    .phase            (phase),
    .line_count       (line_count),
    .space_count      (space_count),
    .phase_next       (phase_next),
    .line_count_next  (line_count_next),
    .space_count_next (space_count_next),
    .result           (result_next)
  );

  assign advance = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_reg <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase <= hhlp_pkg::PH_NAME;
      line_count <= '0;
      space_count <= '0;
    end else begin
      if (advance) begin
        result_valid <= 1'b1;
        phase <= phase_next;
        line_count <= line_count_next;
        space_count <= space_count_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

FILE: design/hhlp_checker.sv
module hhlp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_stall,
  input hhlp_pkg::item_beat_t           item,
  input logic                           result_valid,
  input logic                           result_stall,
  input hhlp_pkg::result_beat_t         result
);

  logic [2:0] ph;
  assign ph = result.phase;

  // held item beat stays put
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("item beat changed while stalled");

  // held result beat stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // name characters only in name phase and always taken
  a_name_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.name_valid |->
      ph == hhlp_pkg::PH_NAME && result.accepted && !result.value_valid)
    else $error("name character outside name phase");

  // value characters only in value phase and always taken
  a_value_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.value_valid |->
      ph == hhlp_pkg::PH_VALUE && result.accepted)
    else $error("value character outside value phase");

  // error phases never take a byte
  a_error_rejects: assert property (@(posedge clk) disable iff (rst)
    result_valid && (ph == hhlp_pkg::PH_ERR_LEN || ph == hhlp_pkg::PH_ERR_WS ||
      ph == hhlp_pkg::PH_ERR_EOL) |-> !result.accepted && result.name_char == 8'd0 &&
      result.value_char == 8'd0)
    else $error("error phase with accepted byte");

endmodule

bind http_header_line_parser_core hhlp_checker u_hhlp_checker (.*);

FILE: tb/http_header_line_parser_core_tb.sv
module http_header_line_parser_core_tb;

  localparam int STUCK_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int LONG_VALUE_BYTES = 64;

  class line_scoreboard;
    hhlp_pkg::result_beat_t expected_q[$];
    int errors;
    hhlp_pkg::phase_t ph;
    logic [hhlp_pkg::LENGTH_BITS_DEFAULT-1:0] line_len;
    logic [7:0] spaces;
    logic [15:0] max_len;
    logic [7:0] max_spaces;
    logic strict;

    function new();
      errors = 0;
      ph = hhlp_pkg::PH_NAME;
      line_len = '0;
      spaces = '0;
      max_len = hhlp_pkg::MAX_LINE_LENGTH_RESET;
      max_spaces = hhlp_pkg::MAX_LEADING_SPACE_RESET;
      strict = hhlp_pkg::STRICT_LINE_END_RESET;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        hhlp_pkg::REG_MAX_LINE_LENGTH: max_len = val[15:0];
        hhlp_pkg::REG_MAX_LEADING_SPACE: max_spaces = val[7:0];
        hhlp_pkg::REG_STRICT_LINE_END: strict = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(hhlp_pkg::item_beat_t it);
      hhlp_pkg::result_beat_t r;
      logic [7:0] c;
      r = '0;
      c = it.byte_in;
      if (it.kind == hhlp_pkg::KIND_CLEAR) begin
        ph = hhlp_pkg::PH_NAME;
        line_len = '0;
        spaces = '0;
      end else begin
        if (line_len != '1) line_len++;
        if (line_len > max_len) ph = hhlp_pkg::PH_ERR_LEN;
        case (ph)
          hhlp_pkg::PH_NAME: begin
            if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
              r.name_valid = 1'b1;
              r.name_char = c | hhlp_pkg::CASE_BIT;
              r.accepted = 1'b1;
            end else if (c == hhlp_pkg::CH_HYPHEN) begin
              r.name_valid = 1'b1;
              r.name_char = c;
              r.accepted = 1'b1;
            end else if (c == hhlp_pkg::CH_COLON) begin
              ph = hhlp_pkg::PH_SPACE;
              r.accepted = 1'b1;
            end
          end
          hhlp_pkg::PH_SPACE, hhlp_pkg::PH_VALUE: begin
            if (ph == hhlp_pkg::PH_SPACE &&
                (c == hhlp_pkg::CH_SPACE || c == hhlp_pkg::CH_TAB)) begin
              if ({1'b0, spaces} + 9'd1 > {1'b0, max_spaces}) begin
                ph = hhlp_pkg::PH_ERR_WS;
              end else begin
                spaces++;
                r.accepted = 1'b1;
              end
            end else if (c == hhlp_pkg::CH_CR) begin
              ph = hhlp_pkg::PH_LF;
              r.accepted = 1'b1;
            end else if (c == hhlp_pkg::CH_LF) begin
              if (strict) begin
                ph = hhlp_pkg::PH_ERR_EOL;
              end else begin
                ph = hhlp_pkg::PH_VALID;
                r.accepted = 1'b1;
              end
            end else begin
              ph = hhlp_pkg::PH_VALUE;
              r.value_valid = 1'b1;
              r.value_char = c;
              r.accepted = 1'b1;
            end
          end
          hhlp_pkg::PH_LF: begin
            if (c == hhlp_pkg::CH_LF) begin
              ph = hhlp_pkg::PH_VALID;
              r.accepted = 1'b1;
            end
          end
          default: ;
        endcase
      end
      r.phase = ph;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void compare(string field, logic [7:0] exp_val, logic [7:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0h, got %0h", field, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(hhlp_pkg::result_beat_t got);
      hhlp_pkg::result_beat_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare("phase", 8'(exp_r.phase), 8'(got.phase));
      compare("accepted", 8'(exp_r.accepted), 8'(got.accepted));
      compare("name_valid", 8'(exp_r.name_valid), 8'(got.name_valid));
      compare("name_char", exp_r.name_char, got.name_char);
      compare("value_valid", 8'(exp_r.value_valid), 8'(got.value_valid));
      compare("value_char", exp_r.value_char, got.value_char);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [hhlp_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [hhlp_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [hhlp_pkg::DATA_BITS-1:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  hhlp_pkg::item_beat_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  hhlp_pkg::result_beat_t result;

  line_scoreboard sb = new();
  int items_sent = 0;
  int stuck_cycles = 0;
  int idle_odds = 4;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  http_header_line_parser_core dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] b);
    if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= {kind, b};
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] len, input logic [31:0] sp,
                            input logic [31:0] strict);
    write_reg(hhlp_pkg::REG_MAX_LINE_LENGTH, len);
    write_reg(hhlp_pkg::REG_MAX_LEADING_SPACE, sp);
    write_reg(hhlp_pkg::REG_STRICT_LINE_END, strict);
  endtask

  function automatic logic [7:0] name_byte();
    case ($urandom_range(0, 7))
      0: return hhlp_pkg::CH_HYPHEN;
      1: return 8'($urandom_range(0, 255));
      2, 3, 4: return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == hhlp_pkg::CH_CR || c == hhlp_pkg::CH_LF);
    return c;
  endfunction

  task automatic send_line();
    int n;
    int lim;
    int ending;
    send_item(hhlp_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)));
    n = $urandom_range(0, 6);
    repeat (n) send_item(hhlp_pkg::KIND_PARSE, name_byte());
    if ($urandom_range(0, 9) != 0) send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_COLON);
    lim = int'(sb.max_spaces) + 1;
    if (lim > 10) lim = 10;
    n = $urandom_range(0, lim);
    repeat (n) begin
      send_item(hhlp_pkg::KIND_PARSE,
                $urandom_range(0, 1) ? hhlp_pkg::CH_SPACE : hhlp_pkg::CH_TAB);
    end
    n = $urandom_range(0, 8);
    repeat (n) send_item(hhlp_pkg::KIND_PARSE, value_byte());
    ending = $urandom_range(0, 5);
    case (ending)
      0, 1: begin
        send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_CR);
        send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_LF);
      end
      2, 3: send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_LF);
      4: begin
        send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_CR);
        send_item(hhlp_pkg::KIND_PARSE, 8'($urandom_range(0, 255)));
        send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_LF);
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      send_item(hhlp_pkg::KIND_PARSE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_item($urandom_range(0, 15) == 0 ? hhlp_pkg::KIND_CLEAR : hhlp_pkg::KIND_PARSE,
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_lines(input int count);
    int stop_at;
    stop_at = items_sent + count;
    idle_odds = $urandom_range(0, 3) * 3;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        send_line();
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: name cases, leading space, value extremes, await lf, finished
    send_item(hhlp_pkg::KIND_CLEAR, 8'hFF);
    send_item(hhlp_pkg::KIND_PARSE, "A");
    send_item(hhlp_pkg::KIND_PARSE, "Z");
    send_item(hhlp_pkg::KIND_PARSE, "z");
    send_item(hhlp_pkg::KIND_PARSE, "@");
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_HYPHEN);
    send_item(hhlp_pkg::KIND_PARSE, "0");
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_COLON);
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_SPACE);
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_TAB);
    send_item(hhlp_pkg::KIND_PARSE, "v");
    send_item(hhlp_pkg::KIND_PARSE, 8'h00);
    send_item(hhlp_pkg::KIND_PARSE, 8'hFF);
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_CR);
    send_item(hhlp_pkg::KIND_PARSE, "x");
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_LF);
    send_item(hhlp_pkg::KIND_PARSE, "q");
    send_item(hhlp_pkg::KIND_CLEAR, 8'h00);
    send_item(hhlp_pkg::KIND_PARSE, "a");
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_COLON);
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_LF);
    drain();

    run_lines(60);

    set_limits(32'd65535, 32'd255, 32'd1);
    run_lines(150);

    set_limits(32'd0, 32'd0, 32'd0);
    run_lines(40);

    set_limits($urandom_range(8, 40), $urandom_range(0, 3), $urandom_range(0, 1));
    hold_req = 1'b1;
    run_lines(150);

    set_limits(32'd1, $urandom_range(0, 255), 32'd1);
    run_lines(40);

    // full-width writes, upper bits must be dropped
    set_limits($urandom(), $urandom(), $urandom());
    run_lines(150);

    set_limits($urandom_range(6, 24), $urandom_range(0, 2), 32'd0);
    run_lines(150);

    // one long value line, no idling from here on
    quiet = 1'b1;
    idle_odds = 0;
    set_limits(32'd65535, 32'd8, 32'd0);
    send_item(hhlp_pkg::KIND_CLEAR, 8'h00);
    send_item(hhlp_pkg::KIND_PARSE, "k");
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_COLON);
    repeat (LONG_VALUE_BYTES) send_item(hhlp_pkg::KIND_PARSE, value_byte());
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_CR);
    send_item(hhlp_pkg::KIND_PARSE, hhlp_pkg::CH_LF);
    send_item(hhlp_pkg::KIND_PARSE, "y");
    drain();
    run_lines(60);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
